@@ sv/arh_pkg.sv @@
// Package for the auto-ranging histogram: sizing constants and the types
// that travel along the row of bin cells. No dependencies.
`default_nettype none

package arh_pkg;

  localparam int NUM_BINS    = 11;
  localparam int MAX_SAMPLES = 1024;

  localparam int SMP_W  = 16;                          // Q8.8 sample
  localparam int BIN_W  = $clog2(NUM_BINS);            // bin index
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);     // sample count, bin count
  localparam int ADDR_W = $clog2(MAX_SAMPLES);         // store address
  localparam int SCL_W  = SMP_W + $clog2(NUM_BINS);    // NUM_BINS * offset
  localparam int STEP_W = $clog2(NUM_BINS + 2);        // phase step counter

  // Scaled sample moving from cell to cell
  typedef struct packed {
    logic             vld;
    logic [SCL_W-1:0] val;
  } hand_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic setup;   // ripple bin edges down the row
    logic clear;   // zero the bin counters
  } ctl_t;

endpackage

`default_nettype wire

@@ sv/arh_cell.sv @@
// One bin cell of the histogram row: holds the bin edges and the bin count,
// passes the scaled sample on to its neighbor. Depends on arh_pkg.
`default_nettype none

module arh_cell import arh_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctl_t             ctl,
  input  logic             open_top,   // last bin: no upper edge
  input  logic [SMP_W-1:0] span,
  input  logic [SCL_W-1:0] lo_in,
  output logic [SCL_W-1:0] hi_out,
  input  hand_t            smp_in,
  output hand_t            smp_out,
  output logic [CNT_W-1:0] count
);

  logic [SCL_W-1:0] lo;
  logic [SCL_W-1:0] lo_next_edge;
  logic             hit;

  assign hi_out = lo_next_edge;

  // Edges: lo = neighbor's upper edge, hi = lo + span
  always_ff @(posedge clk) begin
    if (ctl.setup) begin
      lo           <= lo_in;
      lo_next_edge <= lo_in + SCL_W'(span);
    end
  end

  assign hit = smp_in.vld && (smp_in.val >= lo) &&
               (open_top || (smp_in.val < lo_next_edge));

  always_ff @(posedge clk) begin
    smp_out.val <= smp_in.val;
    if (rst) begin
      count       <= '0;
      smp_out.vld <= 1'b0;
    end else begin
      smp_out.vld <= smp_in.vld;
      if (ctl.clear) begin
        count <= '0;
      end else if (hit) begin
        count <= count + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/auto_range_histogram_top.sv @@
// Top level of the auto-ranging equal-width histogram: sample store,
// min/max tracking, sequencer and the row of arh_cell bin cells.
// Depends on arh_pkg and arh_cell.
//
// Usage
//   Input: a sample transfers at a rising edge where start is high and busy
//   is low. While a set is loading busy stays low, so one sample per cycle
//   may stream in. Up to MAX_SAMPLES samples are kept; further samples are
//   dropped and reported through overflowed. Min and max start from the
//   first sample of the set.
//   A transfer with final_sample high closes the set and raises busy. The
//   block then lays the bin edges down the cell row, streams the N stored
//   samples from the store port into the row (one read per cycle, the
//   store's single read port sets this), drains the row and emits.
//   Output: one result per bin, bin 0 first, each on the ports for exactly
//   one cycle with result_valid high; last_bin marks the final one. Busy
//   drops in the cycle that carries the last result. The receiver cannot
//   stall: results are not held.
//   Reset (rst, synchronous) empties the set and returns to loading; the
//   store needs no clearing because only entries of the current set are read.
`default_nettype none

module auto_range_histogram_top import arh_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [SMP_W-1:0] sample_value,
  input  logic                    final_sample,
  output logic                    result_valid,
  output logic [BIN_W-1:0]        bin_index,
  output logic [CNT_W-1:0]        bin_count,
  output logic signed [SMP_W-1:0] range_low,
  output logic signed [SMP_W-1:0] range_high,
  output logic                    overflowed,
  output logic                    last_bin
);

  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_SETUP = 5'b00010,
    S_SWEEP = 5'b00100,
    S_DRAIN = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;

  // Set state
  logic [SMP_W-1:0]        mem [MAX_SAMPLES];
  logic [CNT_W-1:0]        held;
  logic signed [SMP_W-1:0] mn;
  logic signed [SMP_W-1:0] mx;
  logic                    drop;

  // Sweep pipeline
  logic [ADDR_W-1:0]       rd_addr;
  logic                    rd_vld;
  logic signed [SMP_W-1:0] rd_data;
  hand_t                   scl;
  logic [STEP_W-1:0]       step;

  logic                    accept;
  logic                    room;
  logic [SMP_W-1:0]        span;
  logic [SMP_W-1:0]        off;
  ctl_t                    ctl;

  logic [SCL_W-1:0]        thr [NUM_BINS+1];
  hand_t                   smp [NUM_BINS+1];
  logic [CNT_W-1:0]        cnt [NUM_BINS];

  assign busy   = (state != S_LOAD);
  assign accept = start && !busy;
  assign room   = (held != CNT_W'(MAX_SAMPLES));

  // All stored samples lie within [mn, mx], so both differences fit unsigned
  assign span = SMP_W'(mx - mn);
  assign off  = SMP_W'(rd_data - mn);

  assign ctl.setup = (state == S_SETUP);
  assign ctl.clear = (state == S_SETUP);

  // Sample store: write while loading, one registered read per cycle
  always_ff @(posedge clk) begin
    if (accept && room) begin
      mem[held[ADDR_W-1:0]] <= sample_value;
    end
    rd_data <= mem[rd_addr];
  end

  // Sequencer and set registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      held    <= '0;
      mn      <= '0;
      mx      <= '0;
      drop    <= 1'b0;
      rd_addr <= '0;
      rd_vld  <= 1'b0;
      step    <= '0;
    end else begin
      // the read issued this cycle carries a sample only while sweeping
      rd_vld <= (state == S_SWEEP);
      case (state)
        S_LOAD: begin
          if (accept) begin
            if (room) begin
              held <= held + 1'b1;
              if (held == '0) begin
                mn <= sample_value;
                mx <= sample_value;
              end else begin
                if (sample_value < mn) mn <= sample_value;
                if (sample_value > mx) mx <= sample_value;
              end
            end else begin
              drop <= 1'b1;
            end
            if (final_sample) begin
              state <= S_SETUP;
              step  <= '0;
            end
          end
        end
        S_SETUP: begin
          // hold until the edges have rippled through every cell
          if (step == STEP_W'(NUM_BINS - 1)) begin
            state   <= S_SWEEP;
            step    <= '0;
            rd_addr <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SWEEP: begin
          if (CNT_W'(rd_addr) + 1'b1 == held) begin
            state <= S_DRAIN;
            step  <= '0;
          end else begin
            rd_addr <= rd_addr + 1'b1;
          end
        end
        S_DRAIN: begin
          if (step == STEP_W'(NUM_BINS + 1)) begin
            state <= S_EMIT;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_EMIT: begin
          if (step == STEP_W'(NUM_BINS - 1)) begin
            // set done: drop the set state for the next one
            state <= S_LOAD;
            held  <= '0;
            mn    <= '0;
            mx    <= '0;
            drop  <= 1'b0;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Scale the offset by the bin count so each bin edge is i*span
  always_ff @(posedge clk) begin
    if (rst) begin
      scl.vld <= 1'b0;
    end else begin
      scl.vld <= rd_vld;
    end
    scl.val <= SCL_W'(off) * SCL_W'(NUM_BINS);
  end

  assign thr[0] = '0;
  assign smp[0] = scl;

  for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
    arh_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .open_top (i == NUM_BINS - 1),
      .span     (span),
      .lo_in    (thr[i]),
      .hi_out   (thr[i+1]),
      .smp_in   (smp[i]),
      .smp_out  (smp[i+1]),
      .count    (cnt[i])
    );
  end

  // Result registers: one bin per cycle while emitting
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_EMIT);
    end
    bin_index  <= step[BIN_W-1:0];
    bin_count  <= cnt[step[BIN_W-1:0]];
    range_low  <= mn;
    range_high <= mx;
    overflowed <= drop;
    last_bin   <= (step == STEP_W'(NUM_BINS - 1));
  end

`ifndef SYNTH
  a_busy_after_final: assert property (@(posedge clk) disable iff (rst)
    accept && final_sample |=> busy)
    else $error("busy not raised after final sample");

  a_bins_in_order: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_bin |=> result_valid && (bin_index == $past(bin_index) + 1'b1))
    else $error("results not emitted as a gapless bin sequence");

  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_bin |=> !result_valid)
    else $error("result after last bin");

  a_row_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> !smp[NUM_BINS].vld && !scl.vld && !rd_vld)
    else $error("samples still in the cell row while emitting");

  a_edges_settled: assert property (@(posedge clk) disable iff (rst)
    state == S_SWEEP |-> thr[NUM_BINS] == SCL_W'(span) * SCL_W'(NUM_BINS))
    else $error("bin edges not settled at sweep");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(MAX_SAMPLES))
    else $error("sample count beyond capacity");
`endif

endmodule

`default_nettype wire
